@@ sv/cpdp_pkg.sv @@
`default_nettype none
package cpdp_pkg;

  localparam int FRAC      = 24;
  localparam int MUL_LAT   = 4;
  localparam int DIV_STEPS = 64;
  localparam int DIV_LAT   = DIV_STEPS + 2;

  typedef enum logic [2:0] {
    REG_K1_K2 = 3'd0,
    REG_K3_K4 = 3'd1,
    REG_K5_K6 = 3'd2,
    REG_P1_P2 = 3'd3,
    REG_FX_FY = 3'd4,
    REG_CX_CY = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic signed [63:0] v;
    logic               c;
  } val_t;

  typedef struct packed {
    logic [31:0] v;
    logic        c;
  } s32_t;

  localparam logic [63:0] MAX64 = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
  localparam logic [63:0] ONE_Q = 64'h0000_0000_0100_0000;

  function automatic logic signed [63:0] sext32(input logic [31:0] x);
    return {{32{x[31]}}, x};
  endfunction

  function automatic val_t add_sat(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    val_t        r;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      r.v = s[64] ? MIN64 : MAX64;
      r.c = 1'b1;
    end else begin
      r.v = s[63:0];
      r.c = 1'b0;
    end
    return r;
  endfunction

  function automatic s32_t sat32(input logic [63:0] a);
    s32_t r;
    if (!a[63] && (|a[62:31])) begin
      r.v = 32'h7FFF_FFFF;
      r.c = 1'b1;
    end else if (a[63] && !(&a[62:31])) begin
      r.v = 32'h8000_0000;
      r.c = 1'b1;
    end else begin
      r.v = a[31:0];
      r.c = 1'b0;
    end
    return r;
  endfunction

  function automatic val_t to_signed(input logic neg, input logic [63:0] m, input logic ovf);
    val_t r;
    r.c = 1'b0;
    if (!neg) begin
      if (ovf || m[63]) begin
        r.v = MAX64;
        r.c = 1'b1;
      end else begin
        r.v = m;
      end
    end else begin
      if (ovf || (m[63] && (|m[62:0]))) begin
        r.v = MIN64;
        r.c = 1'b1;
      end else begin
        r.v = ~m + 64'd1;
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ sv/cpdp_mul.sv @@
`default_nettype none
module cpdp_mul (
  input  logic               clk,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  output cpdp_pkg::val_t     y
);
  import cpdp_pkg::*;

  logic [63:0]  ma_r, mb_r;
  logic         sg1_r, sg2_r, sg3_r;
  logic [63:0]  p00_r, p01_r, p10_r, p11_r;
  logic [127:0] pr_r;
  logic [127:0] rnd;

  assign rnd = pr_r + (128'd1 << (FRAC - 1));

  always_ff @(posedge clk) begin
    ma_r  <= a[63] ? (~a + 64'd1) : a;
    mb_r  <= b[63] ? (~b + 64'd1) : b;
    sg1_r <= a[63] ^ b[63];
    p00_r <= ma_r[31:0] * mb_r[31:0];
    p01_r <= ma_r[31:0] * mb_r[63:32];
    p10_r <= ma_r[63:32] * mb_r[31:0];
    p11_r <= ma_r[63:32] * mb_r[63:32];
    sg2_r <= sg1_r;
    pr_r  <= {64'd0, p00_r} + {32'd0, p01_r, 32'd0} + {32'd0, p10_r, 32'd0}
             + {p11_r, 64'd0};
    sg3_r <= sg2_r;
    y     <= to_signed(sg3_r, rnd[FRAC+63:FRAC], |rnd[127:FRAC+64]);
  end

endmodule
`default_nettype wire

@@ sv/cpdp_div.sv @@
`default_nettype none
module cpdp_div (
  input  logic               clk,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  output cpdp_pkg::val_t     y
);
  import cpdp_pkg::*;

  typedef struct packed {
    logic neg;
    logic aneg;
    logic ovf;
    logic zb;
    logic za;
  } dfl_t;

  logic [63:0] na, nb;
  logic [63:0] rem_r [DIV_STEPS+1];
  logic [63:0] q_r   [DIV_STEPS+1];
  logic [63:0] lo_r  [DIV_STEPS+1];
  logic [63:0] nb_r  [DIV_STEPS+1];
  dfl_t        fl_r  [DIV_STEPS+1];
  logic        rup;
  logic [63:0] qn;

  assign na = a[63] ? (~a + 64'd1) : a;
  assign nb = b[63] ? (~b + 64'd1) : b;

  always_ff @(posedge clk) begin
    rem_r[0]     <= na >> (64 - FRAC);
    lo_r[0]      <= na << FRAC;
    q_r[0]       <= '0;
    nb_r[0]      <= nb;
    fl_r[0].neg  <= a[63] ^ b[63];
    fl_r[0].aneg <= a[63];
    fl_r[0].ovf  <= (na >> (64 - FRAC)) >= nb;
    fl_r[0].zb   <= (nb == 64'd0);
    fl_r[0].za   <= (na == 64'd0);
  end

  for (genvar i = 1; i <= DIV_STEPS; i++) begin : g_step
    logic [64:0] trial;
    logic        ge;
    assign trial = {rem_r[i-1], lo_r[i-1][63]};
    assign ge    = trial >= {1'b0, nb_r[i-1]};
    always_ff @(posedge clk) begin
      rem_r[i] <= ge ? 64'(trial - {1'b0, nb_r[i-1]}) : trial[63:0];
      q_r[i]   <= {q_r[i-1][62:0], ge};
      lo_r[i]  <= {lo_r[i-1][62:0], 1'b0};
      nb_r[i]  <= nb_r[i-1];
      fl_r[i]  <= fl_r[i-1];
    end
  end

  assign rup = {rem_r[DIV_STEPS], 1'b0} >= {1'b0, nb_r[DIV_STEPS]};
  assign qn  = q_r[DIV_STEPS] + {63'd0, rup};

  always_ff @(posedge clk) begin
    if (fl_r[DIV_STEPS].zb) begin
      if (fl_r[DIV_STEPS].za) begin
        y.v <= '0;
        y.c <= 1'b0;
      end else begin
        y.v <= fl_r[DIV_STEPS].aneg ? MIN64 : MAX64;
        y.c <= 1'b1;
      end
    end else begin
      y <= to_signed(fl_r[DIV_STEPS].neg, qn,
                     fl_r[DIV_STEPS].ovf | (rup & (&q_r[DIV_STEPS])));
    end
  end

endmodule
`default_nettype wire

@@ sv/camera_point_distortion_projector_top.sv @@
`default_nettype none
// throughput: one item per cycle while out of reset, fully pipelined, no stalls
// the long path is the two chained 64-step restoring dividers
// results cannot be held off; out_strobe marks each for one cycle
// synchronous active-low reset clears valid bits and coefficient registers
module camera_point_distortion_projector_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_point_x,
  input  logic [31:0] in_point_y,
  input  logic [31:0] in_point_z,
  output logic        out_strobe,
  output logic [31:0] out_pixel_u,
  output logic [31:0] out_pixel_v,
  output logic        out_behind_camera,
  output logic        out_zero_depth,
  output logic        out_saturated,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import cpdp_pkg::*;

  localparam int T_XN = DIV_LAT;
  localparam int T_SQ = T_XN + MUL_LAT;
  localparam int T_R2 = T_SQ + 1;
  localparam int T_S  = T_R2 + 1;
  localparam int T_TP = T_SQ + MUL_LAT;
  localparam int T_PS = T_S + MUL_LAT;
  localparam int T_R4 = T_R2 + MUL_LAT;
  localparam int T_R6 = T_R4 + MUL_LAT;
  localparam int T_K3 = T_R6 + MUL_LAT;
  localparam int T_ND = T_K3 + 1;
  localparam int T_XM = T_ND + MUL_LAT;
  localparam int T_XD = T_XM + DIV_LAT;
  localparam int T_A  = T_XD + 1;
  localparam int T_B  = T_A + 1;
  localparam int T_F  = T_B + MUL_LAT;
  localparam int D_XN = T_ND - T_XN;
  localparam int D_TT = T_XD - T_TP;
  localparam int D_PS = T_XD - T_PS;

  typedef struct packed {
    logic v;
    logic zero;
    logic neg;
    logic clip;
  } fl_t;

  logic [63:0] k1k2_r, k3k4_r, k5k6_r, p1p2_r, fxfy_r, cxcy_r;
  logic signed [63:0] k1, k2, k3, k4, k5, k6, p1, p2, fx, fy, cx, cy;

  logic [31:0] x_r, y_r, z_r;
  fl_t         fl_r [T_F+1];
  logic [T_F:0] inj;

  val_t xn, yn, x2, y2, xy, p1xy, p2xy, r4, r6, k1r2, k4r2, k2r4, k5r4, k3r6, k6r6;
  val_t p2sx, p1sy, xm, ym, xd, yd, fxm, fym;
  val_t r2_c, xx2_c, yy2_c, sx_c, sy_c, ttx_c, tty_c, acc1n_c, acc1d_c;
  val_t acc2n_c, acc2d_c, num_c, den_c, xa_c, ya_c, xb_c, yb_c, su_c, sv_c;
  s32_t u32, v32;

  logic [63:0]  r2_r, xx2_r, yy2_r, sx_r, sy_r, num_r, den_r;
  logic [63:0]  xa_r, ya_r, p2sx_a_r, tty_a_r, xb_r, yb_r;
  logic [127:0] nd_r   [D_XN];
  logic [63:0]  r2d_r  [MUL_LAT];
  logic [127:0] acc1_r [MUL_LAT];
  logic [127:0] acc2_r [MUL_LAT];
  logic [63:0]  dend_r [MUL_LAT];
  logic [127:0] tt_r   [D_TT];
  logic [127:0] ps_r   [D_PS];
  logic         out_strobe_r, out_behind_r, out_zero_r, out_sat_r;
  logic [31:0]  out_u_r, out_v_r;
  logic         fin_clip;

  assign busy      = ~rst_n;
  assign cfg_ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k1k2_r <= '0;
      k3k4_r <= '0;
      k5k6_r <= '0;
      p1p2_r <= '0;
      fxfy_r <= '0;
      cxcy_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_K1_K2: k1k2_r <= cfg_data;
        REG_K3_K4: k3k4_r <= cfg_data;
        REG_K5_K6: k5k6_r <= cfg_data;
        REG_P1_P2: p1p2_r <= cfg_data;
        REG_FX_FY: fxfy_r <= cfg_data;
        REG_CX_CY: cxcy_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign k1 = sext32(k1k2_r[63:32]);
  assign k2 = sext32(k1k2_r[31:0]);
  assign k3 = sext32(k3k4_r[63:32]);
  assign k4 = sext32(k3k4_r[31:0]);
  assign k5 = sext32(k5k6_r[63:32]);
  assign k6 = sext32(k5k6_r[31:0]);
  assign p1 = sext32(p1p2_r[63:32]);
  assign p2 = sext32(p1p2_r[31:0]);
  assign fx = sext32(fxfy_r[63:32]);
  assign fy = sext32(fxfy_r[31:0]);
  assign cx = sext32(cxcy_r[63:32]);
  assign cy = sext32(cxcy_r[31:0]);

  // input stage and flag pipeline
  always_ff @(posedge clk) begin
    x_r <= in_point_x;
    y_r <= in_point_y;
    z_r <= in_point_z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int t = 0; t <= T_F; t++) fl_r[t] <= '0;
    end else begin
      fl_r[0].v    <= start & ~busy;
      fl_r[0].zero <= (in_point_z == 32'd0);
      fl_r[0].neg  <= in_point_z[31];
      fl_r[0].clip <= 1'b0;
      for (int t = 0; t < T_F; t++) begin
        fl_r[t+1].v    <= fl_r[t].v;
        fl_r[t+1].zero <= fl_r[t].zero;
        fl_r[t+1].neg  <= fl_r[t].neg;
        fl_r[t+1].clip <= fl_r[t].clip | inj[t];
      end
    end
  end

  // normalize by depth
  cpdp_div u_div_xn (.clk(clk), .a(sext32(x_r)), .b(sext32(z_r)), .y(xn));
  cpdp_div u_div_yn (.clk(clk), .a(sext32(y_r)), .b(sext32(z_r)), .y(yn));

  cpdp_mul u_mul_x2 (.clk(clk), .a(xn.v), .b(xn.v), .y(x2));
  cpdp_mul u_mul_y2 (.clk(clk), .a(yn.v), .b(yn.v), .y(y2));
  cpdp_mul u_mul_xy (.clk(clk), .a(xn.v), .b(yn.v), .y(xy));

  always_ff @(posedge clk) begin
    nd_r[0] <= {xn.v, yn.v};
    for (int i = 1; i < D_XN; i++) nd_r[i] <= nd_r[i-1];
  end

  // radius terms
  always_comb begin
    r2_c  = add_sat(x2.v, y2.v);
    xx2_c = add_sat(x2.v, x2.v);
    yy2_c = add_sat(y2.v, y2.v);
    sx_c  = add_sat(r2_r, xx2_r);
    sy_c  = add_sat(r2_r, yy2_r);
    ttx_c = add_sat(p1xy.v, p1xy.v);
    tty_c = add_sat(p2xy.v, p2xy.v);
  end

  always_ff @(posedge clk) begin
    r2_r  <= r2_c.v;
    xx2_r <= xx2_c.v;
    yy2_r <= yy2_c.v;
    sx_r  <= sx_c.v;
    sy_r  <= sy_c.v;
  end

  cpdp_mul u_mul_p1xy (.clk(clk), .a(p1), .b(xy.v), .y(p1xy));
  cpdp_mul u_mul_p2xy (.clk(clk), .a(p2), .b(xy.v), .y(p2xy));
  cpdp_mul u_mul_p2sx (.clk(clk), .a(p2), .b(sx_r), .y(p2sx));
  cpdp_mul u_mul_p1sy (.clk(clk), .a(p1), .b(sy_r), .y(p1sy));

  always_ff @(posedge clk) begin
    tt_r[0] <= {ttx_c.v, tty_c.v};
    for (int i = 1; i < D_TT; i++) tt_r[i] <= tt_r[i-1];
    ps_r[0] <= {p2sx.v, p1sy.v};
    for (int i = 1; i < D_PS; i++) ps_r[i] <= ps_r[i-1];
  end

  // radial polynomials
  cpdp_mul u_mul_r4 (.clk(clk), .a(r2_r), .b(r2_r), .y(r4));
  cpdp_mul u_mul_k1 (.clk(clk), .a(k1), .b(r2_r), .y(k1r2));
  cpdp_mul u_mul_k4 (.clk(clk), .a(k4), .b(r2_r), .y(k4r2));

  always_ff @(posedge clk) begin
    r2d_r[0] <= r2_r;
    for (int i = 1; i < MUL_LAT; i++) r2d_r[i] <= r2d_r[i-1];
  end

  cpdp_mul u_mul_r6 (.clk(clk), .a(r2d_r[MUL_LAT-1]), .b(r4.v), .y(r6));
  cpdp_mul u_mul_k2 (.clk(clk), .a(k2), .b(r4.v), .y(k2r4));
  cpdp_mul u_mul_k5 (.clk(clk), .a(k5), .b(r4.v), .y(k5r4));
  cpdp_mul u_mul_k3 (.clk(clk), .a(k3), .b(r6.v), .y(k3r6));
  cpdp_mul u_mul_k6 (.clk(clk), .a(k6), .b(r6.v), .y(k6r6));

  always_comb begin
    acc1n_c = add_sat(ONE_Q, k1r2.v);
    acc1d_c = add_sat(ONE_Q, k4r2.v);
    acc2n_c = add_sat(acc1_r[MUL_LAT-1][127:64], k2r4.v);
    acc2d_c = add_sat(acc1_r[MUL_LAT-1][63:0], k5r4.v);
    num_c   = add_sat(acc2_r[MUL_LAT-1][127:64], k3r6.v);
    den_c   = add_sat(acc2_r[MUL_LAT-1][63:0], k6r6.v);
  end

  always_ff @(posedge clk) begin
    acc1_r[0] <= {acc1n_c.v, acc1d_c.v};
    acc2_r[0] <= {acc2n_c.v, acc2d_c.v};
    for (int i = 1; i < MUL_LAT; i++) begin
      acc1_r[i] <= acc1_r[i-1];
      acc2_r[i] <= acc2_r[i-1];
    end
    num_r <= num_c.v;
    den_r <= den_c.v;
    dend_r[0] <= den_r;
    for (int i = 1; i < MUL_LAT; i++) dend_r[i] <= dend_r[i-1];
  end

  // radial scaling
  cpdp_mul u_mul_xm (.clk(clk), .a(nd_r[D_XN-1][127:64]), .b(num_r), .y(xm));
  cpdp_mul u_mul_ym (.clk(clk), .a(nd_r[D_XN-1][63:0]), .b(num_r), .y(ym));
  cpdp_div u_div_xd (.clk(clk), .a(xm.v), .b(dend_r[MUL_LAT-1]), .y(xd));
  cpdp_div u_div_yd (.clk(clk), .a(ym.v), .b(dend_r[MUL_LAT-1]), .y(yd));

  // tangential terms
  always_comb begin
    xa_c = add_sat(xd.v, tt_r[D_TT-1][127:64]);
    ya_c = add_sat(yd.v, ps_r[D_PS-1][63:0]);
    xb_c = add_sat(xa_r, p2sx_a_r);
    yb_c = add_sat(ya_r, tty_a_r);
  end

  always_ff @(posedge clk) begin
    xa_r     <= xa_c.v;
    ya_r     <= ya_c.v;
    p2sx_a_r <= ps_r[D_PS-1][127:64];
    tty_a_r  <= tt_r[D_TT-1][63:0];
    xb_r     <= xb_c.v;
    yb_r     <= yb_c.v;
  end

  // pixel mapping
  cpdp_mul u_mul_fx (.clk(clk), .a(fx), .b(xb_r), .y(fxm));
  cpdp_mul u_mul_fy (.clk(clk), .a(fy), .b(yb_r), .y(fym));

  always_comb begin
    su_c = add_sat(fxm.v, cx);
    sv_c = add_sat(fym.v, cy);
    u32  = sat32(su_c.v);
    v32  = sat32(sv_c.v);
  end

  always_comb begin
    inj = '0;
    inj[T_XN] = inj[T_XN] | xn.c | yn.c;
    inj[T_SQ] = inj[T_SQ] | x2.c | y2.c | xy.c | r2_c.c | xx2_c.c | yy2_c.c;
    inj[T_R2] = inj[T_R2] | sx_c.c | sy_c.c;
    inj[T_TP] = inj[T_TP] | p1xy.c | p2xy.c | ttx_c.c | tty_c.c;
    inj[T_PS] = inj[T_PS] | p2sx.c | p1sy.c;
    inj[T_R4] = inj[T_R4] | r4.c | k1r2.c | k4r2.c | acc1n_c.c | acc1d_c.c;
    inj[T_R6] = inj[T_R6] | r6.c | k2r4.c | k5r4.c | acc2n_c.c | acc2d_c.c;
    inj[T_K3] = inj[T_K3] | k3r6.c | k6r6.c | num_c.c | den_c.c;
    inj[T_XM] = inj[T_XM] | xm.c | ym.c;
    inj[T_XD] = inj[T_XD] | xd.c | yd.c | xa_c.c | ya_c.c;
    inj[T_A]  = inj[T_A] | xb_c.c | yb_c.c;
    inj[T_F]  = inj[T_F] | fxm.c | fym.c | su_c.c | sv_c.c | u32.c | v32.c;
  end

  assign fin_clip = fl_r[T_F].clip | inj[T_F];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= fl_r[T_F].v;
    end
    out_u_r      <= fl_r[T_F].zero ? 32'd0 : u32.v;
    out_v_r      <= fl_r[T_F].zero ? 32'd0 : v32.v;
    out_behind_r <= fl_r[T_F].neg & ~fl_r[T_F].zero;
    out_zero_r   <= fl_r[T_F].zero;
    out_sat_r    <= fin_clip & ~fl_r[T_F].zero;
  end

  assign out_strobe        = out_strobe_r;
  assign out_pixel_u       = out_u_r;
  assign out_pixel_v       = out_v_r;
  assign out_behind_camera = out_behind_r;
  assign out_zero_depth    = out_zero_r;
  assign out_saturated     = out_sat_r;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(T_F+2) out_strobe)
    else $error("item result missing at fixed latency");

  a_zero_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_zero_depth) |->
      (out_pixel_u == 32'd0 && out_pixel_v == 32'd0 && !out_saturated
       && !out_behind_camera))
    else $error("zero depth item carries nonzero pixel or flags");

  a_idle_out: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(fl_r[T_F].v) |-> !out_strobe)
    else $error("strobe without item");
`endif

endmodule
`default_nettype wire

@@ bench/camera_point_distortion_projector_top_tb.sv @@
`timescale 1ns / 1ps
module camera_point_distortion_projector_top_tb;
  import cpdp_pkg::*;

  localparam int LATENCY   = 161;
  localparam int MAX_CYCLE = 400000;
  localparam logic [63:0] I64MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] I64MIN = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [31:0] u;
    logic [31:0] v;
    logic        behind;
    logic        zdepth;
    logic        sat;
  } pixel_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        has_exp;
    pixel_t      exp_pix;
  } point_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] in_point_x = '0;
  logic [31:0] in_point_y = '0;
  logic [31:0] in_point_z = '0;
  logic        out_strobe;
  logic [31:0] out_pixel_u;
  logic [31:0] out_pixel_v;
  logic        out_behind_camera;
  logic        out_zero_depth;
  logic        out_saturated;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  logic [63:0] coef [6];
  pixel_t      pending_pix [$];
  int          mismatches = 0;
  int          cycle_count = 0;
  logic        clipped;

  camera_point_distortion_projector_top dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLE) begin
      $display("FAIL camera_point_distortion_projector_top");
      $finish;
    end
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
    mismatches++;
  endtask

  always @(posedge clk) begin
    pixel_t want;
    if (rst_n && out_strobe) begin
      if (pending_pix.size() == 0) begin
        report("unexpected item", out_pixel_u, 32'h0);
      end else begin
        want = pending_pix.pop_front();
        if (out_pixel_u !== want.u) report("pixel_u", out_pixel_u, want.u);
        if (out_pixel_v !== want.v) report("pixel_v", out_pixel_v, want.v);
        if (out_behind_camera !== want.behind)
          report("behind_camera", 32'(out_behind_camera), 32'(want.behind));
        if (out_zero_depth !== want.zdepth)
          report("zero_depth", 32'(out_zero_depth), 32'(want.zdepth));
        if (out_saturated !== want.sat)
          report("saturated", 32'(out_saturated), 32'(want.sat));
      end
    end
  end

  function automatic logic [63:0] sign_fix(logic neg, logic [63:0] m, logic ovf);
    if (!neg) begin
      if (ovf || m[63]) begin clipped = 1'b1; return I64MAX; end
      return m;
    end
    if (ovf || (m[63] && |m[62:0])) begin clipped = 1'b1; return I64MIN; end
    return -m;
  endfunction

  function automatic logic [63:0] magn(logic [63:0] a);
    return a[63] ? -a : a;
  endfunction

  function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b, int s);
    logic [127:0] p;
    p = {64'd0, magn(a)} * {64'd0, magn(b)};
    p = (p + (128'd1 << (s - 1))) >> s;
    return sign_fix(a[63] ^ b[63], p[63:0], |p[127:64]);
  endfunction

  function automatic logic [63:0] qdiv(logic [63:0] a, logic [63:0] b);
    logic [127:0] n, q, r;
    if (b == 0) begin
      if (a == 0) return 0;
      clipped = 1'b1;
      return a[63] ? I64MIN : I64MAX;
    end
    n = {64'd0, magn(a)} << FRAC;
    q = n / {64'd0, magn(b)};
    r = n % {64'd0, magn(b)};
    if ((r << 1) >= {64'd0, magn(b)}) q = q + 1;
    return sign_fix(a[63] ^ b[63], q[63:0], |q[127:64]);
  endfunction

  function automatic logic [63:0] sadd(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin clipped = 1'b1; return s[64] ? I64MIN : I64MAX; end
    return s[63:0];
  endfunction

  function automatic logic [31:0] clamp32(logic [63:0] a);
    if ($signed(a) > 64'sh7FFF_FFFF) begin clipped = 1'b1; return 32'h7FFF_FFFF; end
    if ($signed(a) < -64'sh8000_0000) begin clipped = 1'b1; return 32'h8000_0000; end
    return a[31:0];
  endfunction

  function automatic logic [63:0] half(logic [63:0] r, int upper);
    logic [31:0] h;
    h = upper ? r[63:32] : r[31:0];
    return {{32{h[31]}}, h};
  endfunction

  function automatic logic [63:0] radial_poly(logic [63:0] c1, logic [63:0] c2,
                                              logic [63:0] c3, logic [63:0] r2,
                                              logic [63:0] r4, logic [63:0] r6);
    logic [63:0] acc;
    acc = 64'd1 << FRAC;
    acc = sadd(acc, qmul(c1, r2, FRAC));
    acc = sadd(acc, qmul(c2, r4, FRAC));
    return sadd(acc, qmul(c3, r6, FRAC));
  endfunction

  function automatic pixel_t project_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    logic [63:0] x, y, z, xn, yn, x2, y2, xy, r2, r4, r6, num, den, xd, yd, t;
    logic [63:0] p1, p2;
    pixel_t r;
    clipped = 1'b0;
    r = '0;
    if (pz == 0) begin r.zdepth = 1'b1; return r; end
    x = {{32{px[31]}}, px}; y = {{32{py[31]}}, py}; z = {{32{pz[31]}}, pz};
    p1 = half(coef[REG_P1_P2], 1); p2 = half(coef[REG_P1_P2], 0);
    xn = qdiv(x, z);
    yn = qdiv(y, z);
    x2 = qmul(xn, xn, FRAC);
    y2 = qmul(yn, yn, FRAC);
    xy = qmul(xn, yn, FRAC);
    r2 = sadd(x2, y2);
    r4 = qmul(r2, r2, FRAC);
    r6 = qmul(r2, r4, FRAC);
    num = radial_poly(half(coef[REG_K1_K2], 1), half(coef[REG_K1_K2], 0),
                      half(coef[REG_K3_K4], 1), r2, r4, r6);
    den = radial_poly(half(coef[REG_K3_K4], 0), half(coef[REG_K5_K6], 1),
                      half(coef[REG_K5_K6], 0), r2, r4, r6);
    xd = qdiv(qmul(xn, num, FRAC), den);
    yd = qdiv(qmul(yn, num, FRAC), den);
    t = qmul(p1, xy, FRAC);
    xd = sadd(xd, sadd(t, t));
    xd = sadd(xd, qmul(p2, sadd(r2, sadd(x2, x2)), FRAC));
    yd = sadd(yd, qmul(p1, sadd(r2, sadd(y2, y2)), FRAC));
    t = qmul(p2, xy, FRAC);
    yd = sadd(yd, sadd(t, t));
    r.u = clamp32(sadd(qmul(half(coef[REG_FX_FY], 1), xd, FRAC), half(coef[REG_CX_CY], 1)));
    r.v = clamp32(sadd(qmul(half(coef[REG_FX_FY], 0), yd, FRAC), half(coef[REG_CX_CY], 0)));
    r.behind = pz[31];
    r.sat = clipped;
    return r;
  endfunction

  task automatic write_coef(input reg_idx_t idx, input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    coef[idx] = data;
  endtask

  task automatic drain();
    while (pending_pix.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic send_point(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
                            input logic has_exp, input pixel_t exp_pix, input logic gaps);
    pixel_t want;
    if (gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    start      <= 1'b1;
    in_point_x <= x;
    in_point_y <= y;
    in_point_z <= z;
    @(posedge clk);
    while (busy) @(posedge clk);
    want = has_exp ? exp_pix : project_point(x, y, z);
    pending_pix.push_back(want);
  endtask

  task automatic load_setting(input logic [63:0] k12, input logic [63:0] k34,
                              input logic [63:0] k56, input logic [63:0] p12,
                              input logic [63:0] fxy, input logic [63:0] cxy);
    write_coef(REG_K1_K2, k12);
    write_coef(REG_K3_K4, k34);
    write_coef(REG_K5_K6, k56);
    write_coef(REG_P1_P2, p12);
    write_coef(REG_FX_FY, fxy);
    write_coef(REG_CX_CY, cxy);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
      default: return 32'($signed($urandom_range(0, 4 << 16)) - (2 << 16));
    endcase
  endfunction

  function automatic logic [31:0] rand_coef();
    return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
  endfunction

  point_row_t rows [$];

  initial begin
    pixel_t z0;
    int m;
    logic [31:0] zz;
    for (int i = 0; i < 6; i++) coef[i] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    z0 = '0; z0.zdepth = 1'b1;
    rows.push_back('{32'h0001_0000, 32'h0002_0000, 32'h0, 1'b1, z0});
    rows.push_back('{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b1, z0});
    rows.push_back('{32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b1,
                     '{32'h0, 32'h0, 1'b0, 1'b0, 1'b0}});
    rows.push_back('{32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000, 1'b1,
                     '{32'h0, 32'h0, 1'b1, 1'b0, 1'b0}});
    rows.push_back('{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 1'b0, '0});
    rows.push_back('{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, '0});
    rows.push_back('{32'h0, 32'h0, 32'h7FFF_FFFF, 1'b0, '0});
    rows.push_back('{32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 1'b0, '0});

    foreach (rows[i]) send_point(rows[i].x, rows[i].y, rows[i].z, rows[i].has_exp,
                                 rows[i].exp_pix, 1'b0);
    start <= 1'b0;
    drain();

    // typical lens with focal length 2.0, then extremes
    load_setting({32'hFF80_0000, 32'h0010_0000}, {32'h0001_0000, 32'h0008_0000},
                 {32'h0002_0000, 32'hFFFF_0000}, {32'h0000_4000, 32'hFFFF_C000},
                 {32'h0200_0000, 32'h0200_0000}, {32'h0140_0000, 32'h00F0_0000});
    for (int i = 0; i < 10; i++)
      send_point(rand_coord(1), rand_coord(1), rand_coord(2), 1'b0, '0, 1'b0);
    // denominator forced to zero at unit radius
    start <= 1'b0;
    drain();
    load_setting(64'h0, {32'h0, 32'hFF00_0000}, 64'h0, 64'h0,
                 {32'h7FFF_FFFF, 32'h8000_0000}, {32'h8000_0000, 32'h7FFF_FFFF});
    send_point(32'h0, 32'h0, 32'h0001_0000, 1'b0, '0, 1'b0);
    send_point(32'h0001_0000, 32'h0, 32'h0001_0000, 1'b0, '0, 1'b0);
    send_point(32'hFFFF_0000, 32'h0001_0000, 32'hFFFF_0000, 1'b0, '0, 1'b0);
    start <= 1'b0;
    drain();
    load_setting('1, '1, '1, '1, '1, '1);
    send_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1'b0, '0, 1'b0);
    start <= 1'b0;
    drain();
    load_setting({32'h7FFF_FFFF, 32'h8000_0000}, {32'h7FFF_FFFF, 32'h8000_0000},
                 {32'h7FFF_FFFF, 32'h8000_0000}, {32'h7FFF_FFFF, 32'h8000_0000},
                 {32'h7FFF_FFFF, 32'h7FFF_FFFF}, {32'h8000_0000, 32'h8000_0000});
    send_point(32'h0003_0000, 32'hFFFE_0000, 32'h0001_0000, 1'b0, '0, 1'b0);
    start <= 1'b0;
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      load_setting({rand_coef(), rand_coef()}, {rand_coef(), rand_coef()},
                   {rand_coef(), rand_coef()}, {rand_coef() >>> 4, rand_coef() >>> 4},
                   {$urandom_range(0, 32'h0400_0000), $urandom_range(0, 32'h0400_0000)},
                   {$urandom, $urandom});
      for (int i = 0; i < 100; i++) begin
        m = $urandom_range(0, 9);
        zz = (m == 0) ? $urandom : (m == 1 ? 32'h0 : rand_coord(1));
        if (phase == 4 && i == 50) begin
          start <= 1'b0;
          drain();
        end
        send_point(m < 2 ? $urandom : rand_coord(1), m < 2 ? $urandom : rand_coord(1), zz,
                   1'b0, '0, phase < 4);
      end
      start <= 1'b0;
      drain();
    end

    if (mismatches == 0) begin
      $display("PASS camera_point_distortion_projector_top");
    end else begin
      $display("FAIL camera_point_distortion_projector_top");
    end
    $finish;
  end
endmodule
